[hdl/rgbasc_pkg.sv]
`timescale 1ns / 1ps

package rgbasc_pkg;

  // Pixel and result widths
  localparam int unsigned ChanW  = 8;
  localparam int unsigned SumW   = 10;
  localparam int unsigned GlyphW = 7;
  localparam int unsigned ClassW = 3;

  // Grey threshold after reset
  localparam logic [ChanW-1:0] GreyThrReset = 8'd20;

  // Brightness ramp " .:;=$%@#8W", one step per 75 of r+g+b
  localparam int unsigned RampLen   = 11;
  localparam int unsigned GlyphStep = 75;
  localparam int unsigned RampIdxW  = $clog2(RampLen);
  localparam logic [GlyphW-1:0] GlyphRamp [RampLen] = '{
    7'd32, 7'd46, 7'd58, 7'd59, 7'd61, 7'd36, 7'd37, 7'd64, 7'd35, 7'd56, 7'd87
  };

  // Color classes
  typedef enum logic [ClassW-1:0] {
    ClrGrey    = 3'd0,
    ClrRed     = 3'd1,
    ClrYellow  = 3'd2,
    ClrGreen   = 3'd3,
    ClrCyan    = 3'd4,
    ClrBlue    = 3'd5,
    ClrMagenta = 3'd6
  } color_e;

  typedef struct packed {
    logic [ChanW-1:0] red_in;
    logic [ChanW-1:0] green_in;
    logic [ChanW-1:0] blue_in;
  } pixel_t;

  typedef struct packed {
    logic [GlyphW-1:0] glyph_code;
    logic [ClassW-1:0] color_class;
  } glyph_t;

  // Ramp lookup: index is the number of full steps in the sum (0..10)
  function automatic logic [GlyphW-1:0] glyph_of(input logic [SumW-1:0] sum);
    logic [RampIdxW-1:0] idx;
    idx = '0;
    for (int k = 1; k < RampLen; k++) begin
      if (sum >= SumW'(GlyphStep * k)) idx = RampIdxW'(k);
    end
    return GlyphRamp[idx];
  endfunction

endpackage

[hdl/rgb_pixel_to_ascii_glyph_color.sv]
`timescale 1ns / 1ps

// Channel  | Signals                              | Dir | Item
// ---------+--------------------------------------+-----+---------------------------
// in       | in_valid_i, in_stall_o, in_item_i    | in  | pixel_t (r, g, b)
// out      | out_valid_o, out_stall_i, out_item_o | out | glyph_t (glyph, class)
// cfg      | cfg_we_i, cfg_wdata_i                | in  | grey threshold, 8 bits
//
// Three register stages: compares and sum, max/min/diff and glyph lookup,
// hue rounding into the output register. One item per cycle is accepted
// as long as the output side keeps taking results. Reset clears the stage
// valid bits and loads the grey threshold with 20. Each stage holds while
// the one after it is full and stalled; empty stages fill, so in_stall_o
// rises only when all three stages hold an item.

module rgb_pixel_to_ascii_glyph_color (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  rgbasc_pkg::pixel_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output rgbasc_pkg::glyph_t            out_item_o,
  input  logic                          cfg_we_i,
  input  logic [rgbasc_pkg::ChanW-1:0]  cfg_wdata_i
);
  import rgbasc_pkg::*;

  // Which channel carries the maximum (ties go to red, then green)
  typedef enum logic [1:0] {
    MaxRed   = 2'd0,
    MaxGreen = 2'd1,
    MaxBlue  = 2'd2
  } max_sel_e;

  typedef struct packed {
    logic g_gt_r;
    logic b_gt_r;
    logic b_gt_g;
    logic g_lt_r;
    logic b_lt_r;
    logic b_lt_g;
  } cmp_t;

  // Configuration
  logic [ChanW-1:0] thr_q;

  // Stage A
  logic             va_q;
  pixel_t           pix_a_q;
  logic [SumW-1:0]  sum_a_q;
  cmp_t             cmp_a_q;

  // Stage B
  logic              vb_q;
  logic [ChanW-1:0]  d_b_q;
  logic signed [ChanW:0] diff_b_q;
  max_sel_e          sel_b_q;
  logic [GlyphW-1:0] glyph_b_q;

  // Output stage
  logic   vo_q;
  glyph_t out_q;

  // Stage enables
  logic en_a, en_b, en_o;

  assign en_o       = !vo_q || !out_stall_i;
  assign en_b       = !vb_q || en_o;
  assign en_a       = !va_q || en_b;
  assign in_stall_o = !en_a;

  assign out_valid_o = vo_q;
  assign out_item_o  = out_q;

  // Threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= GreyThrReset;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en_a) va_q <= in_valid_i;
      if (en_b) vb_q <= va_q;
      if (en_o) vo_q <= vb_q;
    end
  end

  // Stage A: channel compares and brightness sum
  cmp_t            cmp_d;
  logic [SumW-1:0] sum_d;

  always_comb begin
    cmp_d.g_gt_r = in_item_i.green_in > in_item_i.red_in;
    cmp_d.b_gt_r = in_item_i.blue_in  > in_item_i.red_in;
    cmp_d.b_gt_g = in_item_i.blue_in  > in_item_i.green_in;
    cmp_d.g_lt_r = in_item_i.green_in < in_item_i.red_in;
    cmp_d.b_lt_r = in_item_i.blue_in  < in_item_i.red_in;
    cmp_d.b_lt_g = in_item_i.blue_in  < in_item_i.green_in;
    sum_d = SumW'(in_item_i.red_in) + SumW'(in_item_i.green_in)
          + SumW'(in_item_i.blue_in);
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      pix_a_q <= in_item_i;
      sum_a_q <= sum_d;
      cmp_a_q <= cmp_d;
    end
  end

  // Stage B: max, min, spread, hue difference, glyph
  max_sel_e              sel_d;
  logic [ChanW-1:0]      mx, mn;
  logic signed [ChanW:0] diff_d;

  always_comb begin
    if (!cmp_a_q.g_gt_r && !cmp_a_q.b_gt_r) begin
      sel_d = MaxRed;
    end else if (!cmp_a_q.b_gt_g) begin
      sel_d = MaxGreen;
    end else begin
      sel_d = MaxBlue;
    end

    if (!cmp_a_q.g_lt_r && !cmp_a_q.b_lt_r) begin
      mn = pix_a_q.red_in;
    end else if (!cmp_a_q.b_lt_g) begin
      mn = pix_a_q.green_in;
    end else begin
      mn = pix_a_q.blue_in;
    end

    unique case (sel_d)
      MaxRed: begin
        mx     = pix_a_q.red_in;
        diff_d = $signed({1'b0, pix_a_q.green_in}) - $signed({1'b0, pix_a_q.blue_in});
      end
      MaxGreen: begin
        mx     = pix_a_q.green_in;
        diff_d = $signed({1'b0, pix_a_q.blue_in}) - $signed({1'b0, pix_a_q.red_in});
      end
      default: begin
        mx     = pix_a_q.blue_in;
        diff_d = $signed({1'b0, pix_a_q.red_in}) - $signed({1'b0, pix_a_q.green_in});
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      d_b_q     <= mx - mn;
      diff_b_q  <= diff_d;
      sel_b_q   <= sel_d;
      glyph_b_q <= glyph_of(sum_a_q);
    end
  end

  // Output stage: round hue to a sector.
  // With |diff| <= d the rounded offset is -1, 0 or +1 from the base sector:
  // t = 2*diff + d; below zero steps back, at or above 2*d steps forward.
  logic signed [ChanW+2:0] t;
  logic                    step_back, step_fwd;
  color_e                  cls;

  always_comb begin
    t = $signed({diff_b_q[ChanW], diff_b_q, 1'b0})
      + $signed({3'b000, d_b_q});
    step_back = t[ChanW+2];
    step_fwd  = !t[ChanW+2] && (t[ChanW+1:0] >= {1'b0, d_b_q, 1'b0});

    if (d_b_q <= thr_q) begin
      cls = ClrGrey;
    end else begin
      unique case (sel_b_q)
        MaxRed:   cls = step_back ? ClrMagenta : (step_fwd ? ClrYellow  : ClrRed);
        MaxGreen: cls = step_back ? ClrYellow  : (step_fwd ? ClrCyan    : ClrGreen);
        default:  cls = step_back ? ClrCyan    : (step_fwd ? ClrMagenta : ClrBlue);
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      out_q.glyph_code  <= glyph_b_q;
      out_q.color_class <= cls;
    end
  end

`ifndef ASSERT_OFF
  // A full pipeline under output stall must push back on the input
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (va_q && vb_q && vo_q && out_stall_i) |-> in_stall_o)
    else $error("full stalled pipeline accepted an item");

  // An empty first stage always takes an item
  a_empty_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !va_q |-> !in_stall_o)
    else $error("input stalled with empty first stage");

  // An item in stage B moves on to the output when the output is free
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vb_q && !vo_q) |=> vo_q)
    else $error("item lost between stage B and output");

  // Delivered class is always a defined code
  a_class_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.color_class != 3'd7))
    else $error("undefined color class");
`endif

endmodule

[sim/glyph_color_checker.sv]
`timescale 1ns / 1ps

// Watches the pixel, result and threshold ports, predicts each glyph/color
// result from its own copy of the grey threshold and checks results in order.
module glyph_color_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  rgbasc_pkg::pixel_t           in_item_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  rgbasc_pkg::glyph_t           out_item_i,
  input  logic                         cfg_we_i,
  input  logic [rgbasc_pkg::ChanW-1:0] cfg_wdata_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  import rgbasc_pkg::*;

  localparam string LumaRamp  = " .:;=$%@#8W";
  localparam int    ReportMax = 10;

  logic [ChanW-1:0] grey_thr;
  glyph_t           expected_glyphs [$];
  int               mismatch_cnt;

  assign fail_count_o = mismatch_cnt;
  assign pending_o    = expected_glyphs.size();

  // Glyph from the brightness ramp, color from the rounded hue sector
  function automatic glyph_t glyph_for_pixel(input pixel_t px, input logic [ChanW-1:0] thr);
    int               r, g, b, hi, lo, d, base, diff, n, sector, idx;
    logic [SumW-1:0]  sum;
    glyph_t           res;
    r   = int'(px.red_in);
    g   = int'(px.green_in);
    b   = int'(px.blue_in);
    sum = SumW'(r) + SumW'(g) + SumW'(b);
    idx = int'(sum) / 75;
    if (idx > 10) idx = 10;
    res.glyph_code = GlyphW'(LumaRamp[idx]);

    hi = r;
    lo = r;
    if (g > hi) hi = g;
    if (g < lo) lo = g;
    if (b > hi) hi = b;
    if (b < lo) lo = b;
    d = hi - lo;
    if (d <= int'(thr)) begin
      res.color_class = ClrGrey;
    end else begin
      // ties resolve red first, then green
      if (r == hi) begin
        base = 0;
        diff = g - b;
      end else if (g == hi) begin
        base = 2;
        diff = b - r;
      end else begin
        base = 4;
        diff = r - g;
      end
      n = base * d + diff;
      if (n < 0) n += 6 * d;
      sector = (2 * n + d) / (2 * d);
      // top sector sits next to 360 degrees, back to red
      if (sector >= 6) sector = 0;
      res.color_class = ClassW'(int'(ClrRed) + sector);
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    glyph_t want;
    if (!rst_ni) begin
      grey_thr     <= GreyThrReset;
      mismatch_cnt = 0;
      expected_glyphs.delete();
    end else begin
      if (cfg_we_i) grey_thr <= cfg_wdata_i;

      // accepted pixel: queue its expected result
      if (in_valid_i && !in_stall_i) begin
        expected_glyphs.push_back(glyph_for_pixel(in_item_i, grey_thr));
      end

      // accepted result: compare with the oldest expectation
      if (out_valid_i && !out_stall_i) begin
        if (expected_glyphs.size() == 0) begin
          if (mismatch_cnt < ReportMax) begin
            $display("%0t: unexpected item glyph=%0d class=%0d", $realtime,
                     out_item_i.glyph_code, out_item_i.color_class);
          end
          mismatch_cnt++;
        end else begin
          want = expected_glyphs.pop_front();
          if (out_item_i.glyph_code !== want.glyph_code ||
              out_item_i.color_class !== want.color_class) begin
            if (mismatch_cnt < ReportMax) begin
              $display("%0t: mismatch glyph exp=%0d act=%0d class exp=%0d act=%0d",
                       $realtime, want.glyph_code, out_item_i.glyph_code,
                       want.color_class, out_item_i.color_class);
            end
            mismatch_cnt++;
          end
        end
      end
    end
  end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import rgbasc_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int SegItems    = 292;
  localparam int NumSegments = 6;
  localparam int DirCount    = 20;

  // Directed pixels as {red, green, blue}
  localparam logic [23:0] DirPixels [DirCount] = '{
    24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
    24'hFFFF00, 24'h00FFFF, 24'hFF00FF,
    24'hFF0064,  // just past magenta, wraps to red
    24'hFF00C8,  // magenta
    24'h191918, 24'h191919, 24'hFFFFFE,  // ramp step edges
    24'h647864, 24'h647964,  // spread at and just above the grey threshold
    24'hC8C80A, 24'h0AC8C8,  // two channels share the maximum
    24'hC86400,  // hue exactly halfway between sectors
    24'h808080, 24'h5A5AA0
  };

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  pixel_t           in_item_i;
  logic             out_valid_o;
  logic             out_stall_i;
  glyph_t           out_item_o;
  logic             cfg_we_i;
  logic [ChanW-1:0] cfg_wdata_i;

  int               fail_count;
  int               pending;
  int               send_idle_pct;
  int               recv_idle_pct;
  int               cycles;
  logic [ChanW-1:0] cur_thr;

  rgb_pixel_to_ascii_glyph_color i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  glyph_color_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_i   (out_item_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Result side back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Run limit
  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Offer one pixel after random idle cycles and hold it until taken
  task automatic send_pixel(input pixel_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= px;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Stop sending and wait until every queued result has come out
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [ChanW-1:0] thr);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= thr;
    cur_thr     = thr;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    int     hi, lo, mid, d;
    pixel_t px;
    in_valid_i    = 1'b0;
    in_item_i     = '0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    rst_ni        = 1'b0;
    send_idle_pct = 12;
    recv_idle_pct = 51;
    cur_thr       = GreyThrReset;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed pixels with the reset threshold
    for (int i = 0; i < DirCount; i++) begin
      send_pixel(pixel_t'(DirPixels[i]));
    end

    for (int seg = 0; seg < NumSegments; seg++) begin
      case (seg)
        0: write_threshold(8'd0);
        1: write_threshold(8'd255);
        2: write_threshold(ChanW'($urandom_range(1, 60)));
        3: write_threshold(8'd1);
        4: write_threshold(ChanW'($urandom_range(255)));
        default: write_threshold(GreyThrReset);
      endcase
      if (seg >= 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (seg >= 2) begin
        send_idle_pct = 51;
        recv_idle_pct = 12;
      end

      for (int i = 0; i < SegItems; i++) begin
        // spread, tie structure and channel order chosen per pixel
        lo  = $urandom_range(255);
        d   = $urandom_range(255);
        case ($urandom_range(7))
          3: d = int'(cur_thr) + $urandom_range(2) - 1;
          5: d = 0;
          default: ;
        endcase
        if (d < 0) d = 0;
        if (d > 255) d = 255;
        if (lo + d > 255) lo = 255 - d;
        hi  = lo + d;
        mid = $urandom_range(hi, lo);
        if ($urandom_range(5) == 0) mid = $urandom_range(1) ? hi : lo;
        case ($urandom_range(7))
          0: px = '{ChanW'(hi),  ChanW'(mid), ChanW'(lo)};
          1: px = '{ChanW'(hi),  ChanW'(lo),  ChanW'(mid)};
          2: px = '{ChanW'(mid), ChanW'(hi),  ChanW'(lo)};
          3: px = '{ChanW'(lo),  ChanW'(hi),  ChanW'(mid)};
          4: px = '{ChanW'(mid), ChanW'(lo),  ChanW'(hi)};
          5: px = '{ChanW'(lo),  ChanW'(mid), ChanW'(hi)};
          default: px = pixel_t'(24'($urandom));
        endcase
        send_pixel(px);
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[rgb_pixel_to_ascii_glyph_color.f]
hdl/rgbasc_pkg.sv
hdl/rgb_pixel_to_ascii_glyph_color.sv
sim/glyph_color_checker.sv
sim/tb_top.sv
